/* src/versioned_page_staging_table_core_defines.svh */
// Assertion macros shared by the staging table RTL.
`ifndef VERSIONED_PAGE_STAGING_TABLE_CORE_DEFINES_SVH
`define VERSIONED_PAGE_STAGING_TABLE_CORE_DEFINES_SVH
// Same-cycle implication, checked outside reset.
`define VPST_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vpst check failed");
// Next-cycle implication, checked outside reset.
`define VPST_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vpst check failed");
`endif

/* src/vpst_pkg.sv */
// Package with the shared types and codes of the staging table.
`timescale 1ns / 1ps
package vpst_pkg;
   localparam logic [1:0] KIND_PUT    = 2'd0;
   localparam logic [1:0] KIND_LOOKUP = 2'd1;
   localparam logic [1:0] KIND_CLEAR  = 2'd2;

   localparam logic STATUS_DONE     = 1'b0;
   localparam logic STATUS_REJECTED = 1'b1;

   localparam logic [8:0] THRESHOLD_RESET = 9'd256;

   typedef struct packed {
      logic [31:0] timeline;
      logic [31:0] space_id;
      logic [31:0] database_id;
      logic [31:0] relation_number;
      logic [3:0]  fork_number;
      logic [7:0]  key_class;
      logic [31:0] block_number;
   } key_type;

   typedef struct packed {
      key_type     key;
      logic [63:0] lsn;
      logic [63:0] seq;
   } record_type;

   // Best-so-far of a lookup as it travels down the chain.
   typedef struct packed {
      logic        valid;
      logic        have;
      logic [63:0] lsn;
      logic [63:0] seq;
   } token_type;
endpackage

/* src/vpst_if.sv */
// Channel interfaces of the staging table: request, response and register write.
`timescale 1ns / 1ps
interface vpst_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [31:0] timeline;
   logic [31:0] space_id;
   logic [31:0] database_id;
   logic [31:0] relation_number;
   logic [3:0]  fork_number;
   logic [7:0]  key_class;
   logic [31:0] block_number;
   logic [63:0] version_lsn;
   logic [63:0] sequence_req;
   modport source (output valid, kind, timeline, space_id, database_id, relation_number,
                   fork_number, key_class, block_number, version_lsn, sequence_req,
                   input ready);
   modport sink (input valid, kind, timeline, space_id, database_id, relation_number,
                 fork_number, key_class, block_number, version_lsn, sequence_req,
                 output ready);
endinterface

interface vpst_rsp_if;
   logic        valid;
   logic        ready;
   logic        status;
   logic        found;
   logic [7:0]  slot;
   logic [63:0] hit_lsn;
   logic [63:0] hit_sequence;
   logic [8:0]  entry_count;
   logic        full_res;
   modport source (output valid, status, found, slot, hit_lsn, hit_sequence, entry_count,
                   full_res, input ready);
   modport sink (input valid, status, found, slot, hit_lsn, hit_sequence, entry_count,
                 full_res, output ready);
endinterface

interface vpst_csr_if;
   logic       valid;
   logic       ready;
   logic [8:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

/* src/versioned_page_staging_table_core.sv */
// Top level of the versioned page staging table: control, chain of slot cells, result register.
//
//   channel | direction | moves
//   req     | in        | one put, lookup or clear item
//   rsp     | out       | one result item per request item
//   csr     | in        | write of the full threshold
//
// Put, clear and unused kinds are registered directly into the result register.
// A lookup latches its query; a token then walks the chain of cells, one per cycle.
// Reset is synchronous and active high; it empties the table and sets the threshold to 256.
// A new item is taken only while no lookup walks the chain and the result register is free.
`timescale 1ns / 1ps
`include "versioned_page_staging_table_core_defines.svh"
module versioned_page_staging_table_core #(
   parameter int CAPACITY = 256
) (
   input logic       clock,
   input logic       reset,
   vpst_req_if.sink  req,
   vpst_rsp_if.source rsp,
   vpst_csr_if.sink  csr
);
   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);

   typedef enum logic [0:0] {ST_IDLE, ST_SCAN} state_type;

   state_type            state_ff;
   logic                 start_ff;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [8:0]           thr_ff;
   vpst_pkg::record_type query_ff, req_rec;
   logic                 accept, put_ok, table_full;

   logic                 rsp_valid_ff, rsp_valid_in, rsp_status_ff, rsp_found_ff;
   logic [7:0]           rsp_slot_ff;
   logic [63:0]          rsp_lsn_ff, rsp_seq_ff;

   vpst_pkg::token_type  tok [0:CAPACITY];
   logic [IDX_W-1:0]     slot_chain [0:CAPACITY];

   // The result register must be free, or emptied in this cycle.
   assign req.ready  = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp.ready);
   assign accept     = req.valid && req.ready;
   assign csr.ready  = 1'b1;
   assign table_full = (32'(count_ff) >= 32'(CAPACITY));
   assign put_ok     = accept && (req.kind == vpst_pkg::KIND_PUT) && !table_full;

   always_comb begin
      req_rec.key.timeline        = req.timeline;
      req_rec.key.space_id        = req.space_id;
      req_rec.key.database_id     = req.database_id;
      req_rec.key.relation_number = req.relation_number;
      req_rec.key.fork_number     = req.fork_number;
      req_rec.key.key_class       = req.key_class;
      req_rec.key.block_number    = req.block_number;
      req_rec.lsn                 = req.version_lsn;
      req_rec.seq                 = req.sequence_req;
   end

   always_comb begin
      count_in = count_ff;
      if (put_ok) begin
         count_in = count_ff + CNT_W'(1);
      end else if (accept && (req.kind == vpst_pkg::KIND_CLEAR)) begin
         count_in = '0;
      end
   end

   // The result register fills on a short item or at the end of a scan and
   // empties when the receiver takes it.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      if (accept && (req.kind != vpst_pkg::KIND_LOOKUP)) begin
         rsp_valid_in = 1'b1;
      end else if ((state_ff == ST_SCAN) && tok[CAPACITY].valid) begin
         rsp_valid_in = 1'b1;
      end
   end

   // The token enters the first cell from the start register, which is set together with the latched query.
   assign tok[0].valid   = start_ff;
   assign tok[0].have    = 1'b0;
   assign tok[0].lsn     = '0;
   assign tok[0].seq     = '0;
   assign slot_chain[0]  = '0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      vpst_cell #(.IDX_W(IDX_W), .CNT_W(CNT_W)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .my_index  (IDX_W'(i)),
         .write_en  (put_ok && (32'(count_ff) == 32'(i))),
         .write_rec (req_rec),
         .query     (query_ff),
         .count     (count_ff),
         .tok_in    (tok[i]),
         .slot_in   (slot_chain[i]),
         .tok_out   (tok[i+1]),
         .slot_out  (slot_chain[i+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_ff     <= 1'b0;
         count_ff     <= '0;
         thr_ff       <= vpst_pkg::THRESHOLD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         start_ff     <= accept && (req.kind == vpst_pkg::KIND_LOOKUP);
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr.valid) begin
            thr_ff <= csr.data;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  rsp_status_ff <= ((req.kind == vpst_pkg::KIND_PUT) && table_full) ?
                                   vpst_pkg::STATUS_REJECTED : vpst_pkg::STATUS_DONE;
                  rsp_found_ff  <= 1'b0;
                  rsp_slot_ff   <= put_ok ? 8'(count_ff) : 8'd0;
                  rsp_lsn_ff    <= '0;
                  rsp_seq_ff    <= '0;
                  if (req.kind == vpst_pkg::KIND_LOOKUP) begin
                     query_ff <= req_rec;
                     state_ff <= ST_SCAN;
                  end
               end
            end
            ST_SCAN: begin
               if (tok[CAPACITY].valid) begin
                  rsp_found_ff <= tok[CAPACITY].have;
                  if (tok[CAPACITY].have) begin
                     rsp_slot_ff <= 8'(slot_chain[CAPACITY]);
                     rsp_lsn_ff  <= tok[CAPACITY].lsn;
                     rsp_seq_ff  <= tok[CAPACITY].seq;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // A zero threshold behaves as one.
   assign rsp.valid        = rsp_valid_ff;
   assign rsp.status       = rsp_status_ff;
   assign rsp.found        = rsp_found_ff;
   assign rsp.slot         = rsp_slot_ff;
   assign rsp.hit_lsn      = rsp_lsn_ff;
   assign rsp.hit_sequence = rsp_seq_ff;
   assign rsp.entry_count  = 9'(count_ff);
   assign rsp.full_res     = (32'(count_ff) >=
                              ((thr_ff == 9'd0) ? 32'd1 : 32'(thr_ff)));

   `VPST_ASSERT_NEXT(a_lookup_scans, clock, reset,
      accept && (req.kind == vpst_pkg::KIND_LOOKUP), (state_ff == ST_SCAN) && start_ff)
   `VPST_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, 32'(count_ff) <= 32'(CAPACITY))
   `VPST_ASSERT_NOW(a_token_only_scan, clock, reset, tok[CAPACITY].valid,
      state_ff == ST_SCAN)
   `VPST_ASSERT_NEXT(a_put_grows, clock, reset, put_ok,
      count_ff == $past(count_ff) + CNT_W'(1))
endmodule

/* src/vpst_cell.sv */
// One slot of the table: holds an entry and updates the passing lookup token.
`timescale 1ns / 1ps
module vpst_cell #(
   parameter int IDX_W = 8,
   parameter int CNT_W = 9
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [IDX_W-1:0]    my_index,
   input  logic                write_en,
   input  vpst_pkg::record_type write_rec,
   input  vpst_pkg::record_type query,
   input  logic [CNT_W-1:0]    count,
   input  vpst_pkg::token_type tok_in,
   input  logic [IDX_W-1:0]    slot_in,
   output vpst_pkg::token_type tok_out,
   output logic [IDX_W-1:0]    slot_out
);
   vpst_pkg::record_type entry_ff;
   vpst_pkg::token_type  tok_ff, tok_in_next;
   logic [IDX_W-1:0]     slot_ff, slot_in_next;
   logic                 live, visible, better;

   always_comb begin
      live = (CNT_W'(my_index) < count) && (entry_ff.key == query.key);
      visible = (entry_ff.lsn < query.lsn) ||
                ((entry_ff.lsn == query.lsn) &&
                 ((query.seq == 64'd0) || (entry_ff.seq == 64'd0) ||
                  (entry_ff.seq <= query.seq)));
      better = !tok_in.have || (entry_ff.lsn > tok_in.lsn) ||
               ((entry_ff.lsn == tok_in.lsn) && (entry_ff.seq >= tok_in.seq));
      tok_in_next  = tok_in;
      slot_in_next = slot_in;
      if (tok_in.valid && live && visible && better) begin
         tok_in_next.have = 1'b1;
         tok_in_next.lsn  = entry_ff.lsn;
         tok_in_next.seq  = entry_ff.seq;
         slot_in_next     = my_index;
      end
   end

   always_ff @(posedge clock) begin
      if (write_en) begin
         entry_ff <= write_rec;
      end
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in_next;
      end
      slot_ff <= slot_in_next;
   end

   assign tok_out  = tok_ff;
   assign slot_out = slot_ff;
endmodule
